/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lgr_pkg.sv */
`default_nettype none

package lgr_pkg;

  localparam int ROW_W = 64;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 7'd64;

  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             first_row;
    logic             last_row;
  } life_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             last;
  } life_out_t;

  // columns below w are in use
  function automatic logic [ROW_W-1:0] width_mask(input logic [CFG_W-1:0] w);
    logic [ROW_W-1:0] m;
    for (int c = 0; c < ROW_W; c++) begin
      m[c] = (CFG_W'(c) < w);
    end
    return m;
  endfunction

  // one generation of the middle row; rows come in already masked
  function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] up,
                                                 input logic [ROW_W-1:0] mid,
                                                 input logic [ROW_W-1:0] dn);
    logic [ROW_W+1:0] a;
    logic [ROW_W+1:0] m;
    logic [ROW_W+1:0] b;
    logic [3:0]       n;
    logic [ROW_W-1:0] res;
    // padded by one dead column on each side: column c sits at c+1
    a = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    b = {1'b0, dn, 1'b0};
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(a[c]) + 4'(a[c+1]) + 4'(a[c+2]) + 4'(m[c]) + 4'(m[c+2])
        + 4'(b[c]) + 4'(b[c+1]) + 4'(b[c+2]);
      if (m[c+1]) begin
        res[c] = (n >= SURVIVE_LOW) && (n <= SURVIVE_HIGH);
      end else begin
        res[c] = (n == BIRTH_COUNT);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/life_generation_rows.sv */
// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_stall   lgr_pkg::life_in_t  (row_bits, first_row, last_row)
// out       from block out_valid / out_stall lgr_pkg::life_out_t (next_row, last)
// cfg       to block   cfg_wr_en             cfg_wr_data = row_width
//
// One row transfer per cycle while the result queue has room; all 64 columns are computed
// side by side while the row sits in the input register. Its results (none, one, or
// two on a last row) enter a 4-entry result queue from that register; out_valid rises
// once they are in the queue. A last row closing a pending row uses two output transfers.
// rst is synchronous; it clears the row history and the queue, row_width goes to 64.
// A held out_stall fills the queue, then in_stall rises.
`default_nettype none

`include "assert_macros.svh"

module life_generation_rows #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire lgr_pkg::life_in_t               in_data,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      lgr_pkg::life_out_t              out_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lgr_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int RW = lgr_pkg::ROW_W;

  // configuration
  logic [lgr_pkg::CFG_W-1:0] row_width;
  logic [lgr_pkg::CFG_W-1:0] used_w;
  logic [RW-1:0]             mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lgr_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // widths above the column limit act as the limit
  assign used_w = (row_width > lgr_pkg::CFG_W'(MAX_WIDTH))
                ? lgr_pkg::CFG_W'(MAX_WIDTH) : row_width;
  assign mask = lgr_pkg::width_mask(used_w);

  // input register
  logic              a_valid;
  lgr_pkg::life_in_t a_item;
  logic              a_adv;
  logic              in_xfer;

  assign in_stall = a_valid && !a_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_xfer) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_item <= in_data;
    end
  end

  // row history
  logic [RW-1:0] upper_row;
  logic [RW-1:0] middle_row;
  logic          row_pending;

  // a first row drops whatever grid was in progress
  logic          pend_eff;
  logic [RW-1:0] up_eff;
  logic [RW-1:0] mid_eff;
  logic [RW-1:0] cur;
  logic [RW-1:0] res_mid;
  logic [RW-1:0] res_cur;
  logic [1:0]    push_n;

  assign pend_eff = row_pending && !a_item.first_row;
  // history rows were masked on arrival, but width may have changed since
  assign up_eff   = pend_eff ? (upper_row & mask) : '0;
  assign mid_eff  = pend_eff ? (middle_row & mask) : '0;
  assign cur      = a_item.row_bits & mask;

  assign res_mid = lgr_pkg::life_row(up_eff, mid_eff, cur) & mask;
  assign res_cur = lgr_pkg::life_row(mid_eff, cur, '0) & mask;

  assign push_n = {1'b0, pend_eff} + {1'b0, a_item.last_row};

  // result queue
  lgr_pkg::life_out_t               q_mem [lgr_pkg::QDEPTH];
  logic [lgr_pkg::QPTR_W-1:0]       wr_ptr;
  logic [lgr_pkg::QPTR_W-1:0]       rd_ptr;
  logic [lgr_pkg::QCNT_W-1:0]       count;
  logic [lgr_pkg::QCNT_W-1:0]       q_free;
  logic                             pop;
  lgr_pkg::life_out_t               slot0;
  lgr_pkg::life_out_t               slot1;
  logic [lgr_pkg::QCNT_W-1:0]       push_cnt;

  // free space from registered count only, so in_stall never sees out_stall
  assign q_free   = lgr_pkg::QCNT_W'(lgr_pkg::QDEPTH) - count;
  assign a_adv    = a_valid && (lgr_pkg::QCNT_W'(push_n) <= q_free);
  assign push_cnt = a_adv ? lgr_pkg::QCNT_W'(push_n) : '0;
  assign pop      = out_valid && !out_stall;

  // pending row's result goes first, the last row's own result after it
  assign slot0.next_row = pend_eff ? res_mid : res_cur;
  assign slot0.last     = !pend_eff;
  assign slot1.next_row = res_cur;
  assign slot1.last     = 1'b1;

  always_ff @(posedge clk) begin
    if (a_adv && (push_n != 2'd0)) begin
      q_mem[wr_ptr] <= slot0;
    end
    if (a_adv && (push_n == 2'd2)) begin
      q_mem[wr_ptr + lgr_pkg::QPTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lgr_pkg::QPTR_W'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + lgr_pkg::QPTR_W'(1);
      end
      count <= count + push_cnt - lgr_pkg::QCNT_W'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = q_mem[rd_ptr];

  // history update as the row leaves the input register; the held rows keep
  // the mask of their own arrival
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row   <= '0;
      middle_row  <= '0;
      row_pending <= 1'b0;
    end else if (a_adv) begin
      if (a_item.last_row) begin
        upper_row   <= '0;
        middle_row  <= '0;
        row_pending <= 1'b0;
      end else begin
        upper_row   <= pend_eff ? middle_row : '0;
        middle_row  <= cur;
        row_pending <= 1'b1;
      end
    end
  end

  // checks
  `ASSERT_CLK(a_q_bound, count <= lgr_pkg::QCNT_W'(lgr_pkg::QDEPTH), "result queue overfilled")
  `ASSERT_CLK(a_last_clears, a_adv && a_item.last_row |=> !row_pending, "pending row after last row")
  `ASSERT_CLK(a_push_fits, a_adv |-> (count + lgr_pkg::QCNT_W'(push_n) <= lgr_pkg::QCNT_W'(lgr_pkg::QDEPTH)), "push beyond free space")

endmodule

`default_nettype wire

/* bench/life_generation_rows_test.sv */
`default_nettype none

module life_generation_rows_test;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no transfer on either channel before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // quiet cycles before a width write, and at the end of the run
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PCT = 28;
  localparam int MAX_COLS = 64;
  localparam logic [lgr_pkg::CFG_W-1:0] WIDTH_MAX_CFG = 7'd127;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  lgr_pkg::life_in_t         in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  lgr_pkg::life_out_t        out_data;
  logic                      cfg_wr_en = 1'b0;
  logic [lgr_pkg::CFG_W-1:0] cfg_wr_data = '0;

  // idling switches, cleared for the quiet stretch
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  // shadow of the block: width register and the two rows of history
  logic [lgr_pkg::CFG_W-1:0] width_shadow = lgr_pkg::ROW_WIDTH_RESET;
  logic [lgr_pkg::ROW_W-1:0] held_upper = '0;
  logic [lgr_pkg::ROW_W-1:0] held_middle = '0;
  bit                        middle_open = 1'b0;

  // next-state rows owed by the block, oldest first
  lgr_pkg::life_out_t owed_rows[$];

  int fail_count = 0;
  int rows_sent = 0;
  int grids_closed = 0;
  int rows_checked = 0;
  int width_writes = 0;
  int hang_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  life_generation_rows uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // columns in use for a register value; anything past 64 acts as 64
  function automatic logic [lgr_pkg::ROW_W-1:0] live_columns(
      input logic [lgr_pkg::CFG_W-1:0] w);
    int cols;
    cols = (w > MAX_COLS) ? MAX_COLS : int'(w);
    if (cols >= lgr_pkg::ROW_W) begin
      return '1;
    end
    return (64'd1 << cols) - 64'd1;
  endfunction

  // one B3/S23 step for the middle row; everything outside the used width
  // is dead, both as a cell and as a neighbor
  function automatic logic [lgr_pkg::ROW_W-1:0] evolve_row(
      input logic [lgr_pkg::ROW_W-1:0] up,
      input logic [lgr_pkg::ROW_W-1:0] mid,
      input logic [lgr_pkg::ROW_W-1:0] dn);
    logic [lgr_pkg::ROW_W-1:0] mask;
    logic [lgr_pkg::ROW_W-1:0] a;
    logic [lgr_pkg::ROW_W-1:0] m;
    logic [lgr_pkg::ROW_W-1:0] b;
    logic [lgr_pkg::ROW_W-1:0] res;
    int                        n;
    int                        k;
    mask = live_columns(width_shadow);
    a = up & mask;
    m = mid & mask;
    b = dn & mask;
    res = '0;
    for (int c = 0; c < lgr_pkg::ROW_W; c++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        k = c + d;
        if (k >= 0 && k < lgr_pkg::ROW_W) begin
          n += int'(a[k]) + int'(b[k]);
          if (d != 0) begin
            n += int'(m[k]);
          end
        end
      end
      if (m[c]) begin
        res[c] = (n >= int'(lgr_pkg::SURVIVE_LOW)) && (n <= int'(lgr_pkg::SURVIVE_HIGH));
      end else begin
        res[c] = (n == int'(lgr_pkg::BIRTH_COUNT));
      end
    end
    return res & mask;
  endfunction

  // advance the shadow by one accepted row and queue what it owes
  function automatic void account_row(input lgr_pkg::life_in_t item);
    logic [lgr_pkg::ROW_W-1:0] cur;
    logic [lgr_pkg::ROW_W-1:0] above;
    cur = item.row_bits & live_columns(width_shadow);
    if (item.first_row) begin
      held_upper = '0;
      held_middle = '0;
      middle_open = 1'b0;
    end
    // a new row closes the one waiting above it
    if (middle_open) begin
      owed_rows.push_back('{next_row: evolve_row(held_upper, held_middle, cur), last: 1'b0});
    end
    above = middle_open ? held_middle : '0;
    if (item.last_row) begin
      owed_rows.push_back('{next_row: evolve_row(above, cur, '0), last: 1'b1});
      held_upper = '0;
      held_middle = '0;
      middle_open = 1'b0;
      grids_closed++;
    end else begin
      held_upper = above;
      held_middle = cur;
      middle_open = 1'b1;
    end
  endfunction

  // one row transfer; valid is left high so back-to-back rows need no
  // second assignment in the same step
  task automatic send_row(input logic [lgr_pkg::ROW_W-1:0] bits, input logic first,
                          input logic last_flag);
    lgr_pkg::life_in_t item;
    item.row_bits = bits;
    item.first_row = first;
    item.last_row = last_flag;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    account_row(item);
    rows_sent++;
  endtask

  // always lets one edge pass, so the next row is driven in a later step
  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (owed_rows.size() != 0);
  endtask

  // width writes only with the block empty; a row with no result yet may
  // still sit in the input register, hence the settle cycles
  task automatic set_row_width(input logic [lgr_pkg::CFG_W-1:0] w);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_shadow = w;
    width_writes++;
  endtask

  function automatic logic [lgr_pkg::ROW_W-1:0] random_row();
    logic [lgr_pkg::ROW_W-1:0] a;
    logic [lgr_pkg::ROW_W-1:0] b;
    logic [lgr_pkg::ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a;
      1: return a & b;
      2: return a & b & c;
      3: return a | b;
      4: return 64'h7 << $urandom_range(61);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // receiver side: random stalls unless in the quiet stretch
  always @(posedge clk) begin
    out_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
  end

  // result checker: every output transfer is matched against the oldest owed row
  always @(posedge clk) begin
    lgr_pkg::life_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_rows.size() == 0) begin
        $error("unexpected result: next_row %h last %b", out_data.next_row, out_data.last);
        fail_count++;
      end else begin
        want = owed_rows.pop_front();
        rows_checked++;
        if (out_data.next_row !== want.next_row) begin
          $error("next_row mismatch: expected %h, got %h", want.next_row,
                 out_data.next_row);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // hang detector: no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results still owed", HANG_LIMIT,
               owed_rows.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // full width: corners of the grid, edge columns, solid rows, and rows
  // arriving without a start flag
  task automatic test_full_width_edges();
    send_row('1, 1'b1, 1'b1);                     // lone row, dead above and below
    send_row(64'h8000_0000_0000_0001, 1'b1, 1'b0); // vertical blinkers at both edges
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0); // no start flag after a closed grid
    send_row(64'h5555_5555_5555_5555, 1'b0, 1'b1);
  endtask

  // a start flag while a row is still open drops that row silently
  task automatic test_unfinished_grid();
    send_row('1, 1'b1, 1'b0);
    send_row(64'h0F0F_F0F0_3C3C_C3C3, 1'b0, 1'b0);
    send_row(64'h7, 1'b1, 1'b0);
    send_row(64'h7, 1'b0, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_row_width('0);            // nothing in use: every result is zero
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    set_row_width(WIDTH_MAX_CFG); // clamps to 64
    send_row('1, 1'b1, 1'b1);
    set_row_width(7'd1);
    send_row('1, 1'b1, 1'b0);
    send_row('1, 1'b0, 1'b1);
    set_row_width(7'd65);
    send_row(64'hC000_0000_0000_0003, 1'b1, 1'b1);
  endtask

  // rows already held were masked with the old width; results use the new one
  task automatic test_width_change_mid_grid();
    set_row_width(7'd3);
    send_row('1, 1'b1, 1'b0);
    set_row_width(7'd64);
    send_row('1, 1'b0, 1'b0);
    set_row_width(7'd2);
    send_row('1, 1'b0, 1'b1);
  endtask

  // mostly whole grids with random content; some loose rows with random flags
  task automatic test_random_grids();
    logic [lgr_pkg::CFG_W-1:0] w;
    int                        stop_at;
    int                        height;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: w = 7'd64;
        1: w = lgr_pkg::CFG_W'($urandom_range(1, 63));
        2: w = 7'd64;
        3: w = WIDTH_MAX_CFG;
        4: w = '0;
        default: w = lgr_pkg::CFG_W'($urandom_range(0, 127));
      endcase
      set_row_width(w);
      // phase 2 is the stretch with no idling on either side
      gaps_on = (phase != 2);
      stalls_on = (phase != 2);
      stop_at = rows_sent + ((phase == 4) ? 60 : 255);
      while (rows_sent < stop_at) begin
        if ($urandom_range(99) < 12) begin
          send_row(random_row(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          height = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
          for (int r = 0; r < height; r++) begin
            send_row(random_row(), r == 0, r == height - 1);
          end
        end
        // sender holds off until the block has nothing left to deliver
        if ($urandom_range(39) == 0) begin
          drain_results();
        end
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_full_width_edges();
    test_unfinished_grid();
    test_width_extremes();
    test_width_change_mid_grid();
    test_random_grids();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d rows closing %0d grids; %0d next-state rows checked",
             rows_sent, grids_closed, rows_checked);
    $display("%0d width writes incl. 0, 1, 64, 65 and 127, plus width changes mid-grid",
             width_writes);
    if (fail_count == 0 && owed_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
